// ===== hdl/bhc_pkg.sv =====
// ============================================================================
// bhc_pkg
// Types, codes and character mapping functions shared by the base64 / hex
// codec front end, command queue and result serializer.
// ============================================================================
`default_nettype none

package bhc_pkg;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MODE = 1'b0;

   // Operating modes
   localparam logic [1:0] MODE_B64_ENC = 2'd0;
   localparam logic [1:0] MODE_B64_DEC = 2'd1;
   localparam logic [1:0] MODE_HEX_ENC = 2'd2;
   localparam logic [1:0] MODE_HEX_DEC = 2'd3;

   // Command queue geometry
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Result index within one group
   localparam int IDX_W = 2;

   // Kind of group handed from the front end to the serializer
   typedef enum logic [1:0] {
      KIND_B64_ENC = 2'd0,   // four alphabet characters from 24 bits
      KIND_B64_DEC = 2'd1,   // three bytes from 24 bits
      KIND_HEX_ENC = 2'd2,   // two hex characters from one byte
      KIND_BYTE    = 2'd3    // one byte as is (hex decode, incomplete group)
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [23:0] bits;
      logic        last;
      logic        err;
   } cmd_type;

   // Index of the final result of a group of the given kind
   function automatic logic [IDX_W-1:0] final_idx(input kind_type kind);
      logic [IDX_W-1:0] f;
      unique case (kind)
         KIND_B64_ENC: f = IDX_W'(3);
         KIND_B64_DEC: f = IDX_W'(2);
         KIND_HEX_ENC: f = IDX_W'(1);
         default:      f = IDX_W'(0);
      endcase
      return f;
   endfunction

   // Six-bit value to base64 alphabet character
   function automatic logic [7:0] sym_of_six(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (v <= 6'd25)      c = w + 8'd65;
      else if (v <= 6'd51) c = w + 8'd71;
      else if (v <= 6'd61) c = w - 8'd4;
      else if (v == 6'd62) c = 8'd43;
      else                 c = 8'd47;
      return c;
   endfunction

   // Base64 alphabet character to six-bit value; bit 6 marks an invalid code
   function automatic logic [6:0] six_of_sym(input logic [7:0] c);
      logic [7:0] d;
      logic [6:0] r;
      d = 8'd0;
      if (c >= 8'd65 && c <= 8'd90) begin
         d = c - 8'd65;
         r = {1'b0, d[5:0]};
      end else if (c >= 8'd97 && c <= 8'd122) begin
         d = c - 8'd71;
         r = {1'b0, d[5:0]};
      end else if (c >= 8'd48 && c <= 8'd57) begin
         d = c + 8'd4;
         r = {1'b0, d[5:0]};
      end else if (c == 8'd43) begin
         r = 7'd62;
      end else if (c == 8'd47) begin
         r = 7'd63;
      end else begin
         r = 7'd64;
      end
      return r;
   endfunction

   // Nibble to upper-case hex character
   function automatic logic [7:0] hex_of_nib(input logic [3:0] v);
      logic [7:0] w;
      w = {4'h0, v};
      return (v <= 4'd9) ? (w + 8'd48) : (w + 8'd55);
   endfunction

   // Hex character of either case to nibble; bit 4 marks an invalid code
   function automatic logic [4:0] nib_of_hex(input logic [7:0] c);
      logic [7:0] d;
      logic [4:0] r;
      d = 8'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
         d = c - 8'd48;
         r = {1'b0, d[3:0]};
      end else if (c >= 8'd65 && c <= 8'd70) begin
         d = c - 8'd55;
         r = {1'b0, d[3:0]};
      end else if (c >= 8'd97 && c <= 8'd102) begin
         d = c - 8'd87;
         r = {1'b0, d[3:0]};
      end else begin
         r = 5'd16;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bhc_front.sv =====
// ============================================================================
// bhc_front
// Front end: holds the mode register and the partial group, takes one input
// byte per transfer and issues a group command when a group completes or a
// message ends early.
// ============================================================================
`default_nettype none

module bhc_front
   import bhc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       mode_we,
   input  wire logic [1:0] mode_wdata,
   output logic      [1:0] mode,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_last,
   output logic            cmd_push,
   output cmd_type         cmd
);

   logic [1:0]  mode_ff,  mode_in;
   logic [23:0] bits_ff,  bits_in;
   logic [1:0]  count_ff, count_in;
   logic        bad_ff,   bad_in;

   logic [6:0]  six;
   logic [4:0]  nib;
   logic        bad_char;
   logic [23:0] shifted;
   logic        group_done;
   cmd_type     done_cmd;

   // Classify the byte and build the next group image
   always_comb begin
      six        = six_of_sym(in_byte);
      nib        = nib_of_hex(in_byte);
      bad_char   = 1'b0;
      shifted    = bits_ff;
      group_done = 1'b0;
      done_cmd   = '{kind: KIND_BYTE, bits: 24'd0, last: in_last, err: 1'b0};
      unique case (mode_ff)
         MODE_B64_ENC: begin
            shifted       = {bits_ff[15:0], in_byte};
            group_done    = (count_ff == 2'd2);
            done_cmd.kind = KIND_B64_ENC;
         end
         MODE_B64_DEC: begin
            bad_char      = six[6];
            shifted       = {bits_ff[17:0], (six[6] ? 6'd0 : six[5:0])};
            group_done    = (count_ff == 2'd3);
            done_cmd.kind = KIND_B64_DEC;
         end
         MODE_HEX_ENC: begin
            shifted       = {16'd0, in_byte};
            group_done    = 1'b1;
            done_cmd.kind = KIND_HEX_ENC;
         end
         MODE_HEX_DEC: begin
            bad_char      = nib[4];
            shifted       = {bits_ff[19:0], (nib[4] ? 4'd0 : nib[3:0])};
            group_done    = (count_ff == 2'd1);
            done_cmd.kind = KIND_BYTE;
         end
         default: begin
            group_done = 1'b0;
         end
      endcase
      done_cmd.bits = shifted;
      done_cmd.err  = bad_ff | bad_char;
   end

   // Advance the group, issue a command on completion or early end
   always_comb begin
      mode_in  = mode_ff;
      bits_in  = bits_ff;
      count_in = count_ff;
      bad_in   = bad_ff;
      cmd_push = 1'b0;
      cmd      = done_cmd;
      if (mode_we) begin
         mode_in  = mode_wdata;
         bits_in  = 24'd0;
         count_in = 2'd0;
         bad_in   = 1'b0;
      end else if (in_valid) begin
         if (group_done) begin
            cmd_push = 1'b1;
            bits_in  = 24'd0;
            count_in = 2'd0;
            bad_in   = 1'b0;
         end else if (in_last) begin
            // drop the partial group and flag it
            cmd_push = 1'b1;
            cmd      = '{kind: KIND_BYTE, bits: 24'd0, last: 1'b1, err: 1'b1};
            bits_in  = 24'd0;
            count_in = 2'd0;
            bad_in   = 1'b0;
         end else begin
            bits_in  = shifted;
            count_in = count_ff + 2'd1;
            bad_in   = bad_ff | bad_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_B64_ENC;
         bits_ff  <= 24'd0;
         count_ff <= 2'd0;
         bad_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         bits_ff  <= bits_in;
         count_ff <= count_in;
         bad_ff   <= bad_in;
      end
   end

   assign mode = mode_ff;

endmodule

`default_nettype wire

// ===== hdl/bhc_queue.sv =====
// ============================================================================
// bhc_queue
// Short command queue between front end and serializer; head is readable
// directly and leaves on pop.
// ============================================================================
`default_nettype none

module bhc_queue
   import bhc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output cmd_type      head
);

   cmd_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [Q_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = slot_ff[rptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wptr_in  = do_push ? (wptr_ff + Q_PTR_W'(1)) : wptr_ff;
      rptr_in  = do_pop  ? (rptr_ff + Q_PTR_W'(1)) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + Q_CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - Q_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bhc_back.sv =====
// ============================================================================
// bhc_back
// Serializer: walks the head command one result per cycle into a result
// register that the consumer drains with pop; a result held unpopped stalls it.
// ============================================================================
`default_nettype none

module bhc_back
   import bhc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_empty,
   input  wire cmd_type    q_head,
   output logic            q_pop,
   output logic            out_empty,
   input  wire logic       out_pop,
   output logic      [7:0] out_byte,
   output logic            out_last,
   output logic            out_error
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             err_ff,  err_in;

   logic [IDX_W-1:0] fin;
   logic             at_end;
   logic             step;
   logic [5:0]       six;

   assign fin    = final_idx(q_head.kind);
   assign at_end = (idx_ff == fin);
   assign step   = ~q_empty & (~valid_ff | out_pop);

   // Select the result for the current index
   always_comb begin
      six     = q_head.bits[5:0];
      byte_in = q_head.bits[7:0];
      err_in  = q_head.err;
      last_in = q_head.last & at_end;
      unique case (idx_ff)
         2'd0:    six = q_head.bits[23:18];
         2'd1:    six = q_head.bits[17:12];
         2'd2:    six = q_head.bits[11:6];
         default: six = q_head.bits[5:0];
      endcase
      unique case (q_head.kind)
         KIND_B64_ENC: begin
            byte_in = sym_of_six(six);
            err_in  = 1'b0;
         end
         KIND_B64_DEC: begin
            unique case (idx_ff)
               2'd0:    byte_in = q_head.bits[23:16];
               2'd1:    byte_in = q_head.bits[15:8];
               default: byte_in = q_head.bits[7:0];
            endcase
         end
         KIND_HEX_ENC: begin
            byte_in = hex_of_nib((idx_ff == 2'd0) ? q_head.bits[7:4] : q_head.bits[3:0]);
            err_in  = 1'b0;
         end
         default: begin
            byte_in = q_head.bits[7:0];
         end
      endcase
   end

   // Advance index, release the command after its final result
   always_comb begin
      idx_in   = idx_ff;
      q_pop    = 1'b0;
      valid_in = valid_ff & ~out_pop;
      if (step) begin
         valid_in = 1'b1;
         if (at_end) begin
            idx_in = '0;
            q_pop  = 1'b1;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the result payload until the next load
   always_ff @(posedge clock) begin
      if (step) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

   assign out_empty = ~valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_error = err_ff;

   // Index never runs past the final result of the head command
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (idx_ff <= fin))
      else $error("serializer index past final result");

   // Index restarts whenever no command is waiting
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> (idx_ff == '0))
      else $error("serializer index not at start while queue empty");

   // A command leaves only together with a result load
   a_pop_load: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !out_empty)
      else $error("command released without a result");

endmodule

`default_nettype wire

// ===== hdl/base64_hex_codec_unit.sv =====
// ============================================================================
// base64_hex_codec_unit
// Streaming base64 / hex encoder and decoder, selected by the mode register.
// ============================================================================
//
// Usage:
//   Input channel (req_): push a byte with req_push while req_full is low;
//   req_in_last marks the final byte of a message. Result channel (rsp_):
//   a result waits on the rsp_ ports while rsp_empty is low and is taken
//   with rsp_pop. Register mode (address 0) selects base64 encode, base64
//   decode, hex encode or hex decode; writing it drops any partial group.
//   Write it only while nothing is in flight.
// Path: the command of a group enters the command queue with the byte that
//   completes the group (or ends the message early); its results then load the result register.
// Flow: one byte is taken per cycle while req_full is low; results leave one
//   per cycle from the serializer while the consumer pops, so the sustained
//   rate is set by results per byte: base64 encode gives four per three bytes,
//   hex encode two per byte, base64 decode three per four and hex decode one per two.
// Stall: when the consumer holds off, the four-entry command queue fills
//   and req_full rises; nothing is lost.
// Reset: mode returns to base64 encode, group state and queue are cleared and
//   the result register is emptied.
//
`default_nettype none

module base64_hex_codec_unit
   import bhc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   // input channel
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [7:0]            req_in_byte,
   input  wire logic                  req_in_last,
   // result channel
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic      [7:0]            rsp_out_byte,
   output logic                       rsp_out_last,
   output logic                       rsp_error
);

   logic       csr_index;
   logic       mode_we;
   logic [1:0] mode;
   logic       in_valid;
   logic       cmd_push;
   cmd_type    cmd;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   cmd_type    q_head;

   // Decode the register transfer
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1];
   assign mode_we    = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_index == CSR_IDX_MODE);
   assign csr_prdata = (csr_index == CSR_IDX_MODE)
                       ? {{(CSR_DATA_W-2){1'b0}}, mode} : '0;

   assign req_full = q_full;
   assign in_valid = req_push & ~q_full;

   bhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode_we    (mode_we),
      .mode_wdata (csr_pwdata[1:0]),
      .mode       (mode),
      .in_valid   (in_valid),
      .in_byte    (req_in_byte),
      .in_last    (req_in_last),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   bhc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   bhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_out_last),
      .out_error (rsp_error)
   );

endmodule

`default_nettype wire

// ===== test/base64_hex_codec_check.sv =====
// ============================================================================
// base64_hex_codec_check
// Watches the register port and both queue channels of the codec. Keeps its
// own copy of the mode and group state, works out the characters or bytes
// each accepted input byte must produce, and compares every popped result
// against the oldest outstanding prediction.
// ============================================================================
`default_nettype none

module base64_hex_codec_check
   import bhc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                  csr_pready,
   input  wire logic                  req_push,
   input  wire logic                  req_full,
   input  wire logic [7:0]            req_in_byte,
   input  wire logic                  req_in_last,
   input  wire logic                  rsp_empty,
   input  wire logic                  rsp_pop,
   input  wire logic [7:0]            rsp_out_byte,
   input  wire logic                  rsp_out_last,
   input  wire logic                  rsp_error,
   output int                         fail_count,
   output int                         expected_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } codec_result_type;

   codec_result_type expected_results[$];

   // Shadow of the mode register and the partial group
   logic [1:0]  cur_mode;
   logic [23:0] grp_bits;
   logic [1:0]  grp_count;
   logic        grp_bad;

   initial fail_count = 0;

   // Six-bit value to base64 alphabet character
   function automatic logic [7:0] b64_symbol(input logic [5:0] v);
      if (v < 6'd26) return 8'("A" + v);
      if (v < 6'd52) return 8'("a" + (v - 6'd26));
      if (v < 6'd62) return 8'("0" + (v - 6'd52));
      return (v == 6'd62) ? 8'("+") : 8'("/");
   endfunction

   // Base64 alphabet character to six-bit value
   function automatic logic [5:0] b64_value(input logic [7:0] c, output logic valid);
      valid = 1'b1;
      if (c >= "A" && c <= "Z") return 6'(c - "A");
      if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
      if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
      if (c == "+") return 6'd62;
      if (c == "/") return 6'd63;
      valid = 1'b0;
      return 6'd0;
   endfunction

   // Nibble to upper-case hex character
   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? 8'("0" + v) : 8'("A" + (v - 4'd10));
   endfunction

   // Hex character of either case to nibble
   function automatic logic [3:0] hex_value(input logic [7:0] c, output logic valid);
      valid = 1'b1;
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      valid = 1'b0;
      return 4'd0;
   endfunction

   function automatic void clear_group();
      grp_bits  = '0;
      grp_count = '0;
      grp_bad   = 1'b0;
   endfunction

   // Work out the results caused by one accepted input byte
   function automatic void predict_codec(input logic [7:0] b, input logic last);
      logic [23:0] bits;
      logic [5:0]  six;
      logic [3:0]  nib;
      logic        valid;
      logic        done;
      done = 1'b0;
      case (cur_mode)
         MODE_HEX_ENC: begin
            expected_results.push_back('{hex_digit(b[7:4]), 1'b0, 1'b0});
            expected_results.push_back('{hex_digit(b[3:0]), last, 1'b0});
            done = 1'b1;
         end
         MODE_B64_ENC: begin
            bits = {grp_bits[15:0], b};
            grp_bits = bits;
            if (grp_count == 2'd2) begin
               expected_results.push_back('{b64_symbol(bits[23:18]), 1'b0, 1'b0});
               expected_results.push_back('{b64_symbol(bits[17:12]), 1'b0, 1'b0});
               expected_results.push_back('{b64_symbol(bits[11:6]), 1'b0, 1'b0});
               expected_results.push_back('{b64_symbol(bits[5:0]), last, 1'b0});
               done = 1'b1;
            end
         end
         MODE_B64_DEC: begin
            six = b64_value(b, valid);
            if (!valid) grp_bad = 1'b1;
            bits = {grp_bits[17:0], six};
            grp_bits = bits;
            if (grp_count == 2'd3) begin
               expected_results.push_back('{bits[23:16], 1'b0, grp_bad});
               expected_results.push_back('{bits[15:8], 1'b0, grp_bad});
               expected_results.push_back('{bits[7:0], last, grp_bad});
               done = 1'b1;
            end
         end
         default: begin
            nib = hex_value(b, valid);
            if (!valid) grp_bad = 1'b1;
            bits = {grp_bits[19:0], nib};
            grp_bits = bits;
            if (grp_count == 2'd1) begin
               expected_results.push_back('{bits[7:0], last, grp_bad});
               done = 1'b1;
            end
         end
      endcase
      if (done) begin
         clear_group();
      end else begin
         grp_count = grp_count + 2'd1;
         // message ended inside a group: drop it, flag one error result
         if (last) begin
            expected_results.push_back('{8'h00, 1'b1, 1'b1});
            clear_group();
         end
      end
   endfunction

   // Compare one popped result with the oldest prediction
   function automatic void compare_result();
      codec_result_type exp_res;
      if (expected_results.size() == 0) begin
         $display("%0t: unexpected result, got byte %h last %b error %b",
                  $time, rsp_out_byte, rsp_out_last, rsp_error);
         fail_count++;
         return;
      end
      exp_res = expected_results.pop_front();
      if (rsp_out_byte !== exp_res.data) begin
         $display("%0t: out_byte mismatch, expected %h, got %h",
                  $time, exp_res.data, rsp_out_byte);
         fail_count++;
      end
      if (rsp_out_last !== exp_res.last) begin
         $display("%0t: out_last mismatch, expected %b, got %b",
                  $time, exp_res.last, rsp_out_last);
         fail_count++;
      end
      if (rsp_error !== exp_res.err) begin
         $display("%0t: error mismatch, expected %b, got %b",
                  $time, exp_res.err, rsp_error);
         fail_count++;
      end
   endfunction

   // Track register writes, result transfers and input transfers
   always @(posedge clock) begin
      if (reset) begin
         cur_mode = MODE_B64_ENC;
         clear_group();
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_MODE) begin
            cur_mode = csr_pwdata[1:0];
            clear_group();
         end
         // a result popped now can only stem from an earlier input
         if (rsp_pop && !rsp_empty) compare_result();
         if (req_push && !req_full) predict_codec(req_in_byte, req_in_last);
      end
      expected_count = expected_results.size();
   end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ============================================================================
// tb
// Stimulus for the base64 / hex codec: directed groups in every mode, then
// random messages per mode with random sender gaps and consumer stalls.
// Results are predicted and checked by base64_hex_codec_check.
// ============================================================================
`default_nettype none

module tb
   import bhc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 20;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MODE  = CSR_ADDR_W'(4 * CSR_IDX_MODE);
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = CSR_ADDR_W'(4);

   localparam string B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam string HEX_DIGITS = "0123456789ABCDEFabcdef";

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_push    = 1'b0;
   logic                  req_full;
   logic [7:0]            req_in_byte = '0;
   logic                  req_in_last = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop     = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_out_last;
   logic                  rsp_error;

   int fail_count;
   int expected_count;
   int cycle_count;
   bit sender_steady = 1'b0;
   bit pop_steady    = 1'b0;
   int stall_left    = 0;

   base64_hex_codec_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_error    (rsp_error)
   );

   base64_hex_codec_check codec_check (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_error      (rsp_error),
      .fail_count     (fail_count),
      .expected_count (expected_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Consumer: pop with random stalls, steady stretches on request
   initial begin
      forever begin
         @(posedge clock);
         if (pop_steady) begin
            rsp_pop <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
            if ($urandom_range(0, 7) == 0)
               stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
         end
      end
   end

   // Watchdog
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // Register write: setup cycle, then access cycle
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Set the mode with random upper data bits
   task automatic write_mode(input logic [1:0] mode);
      csr_write(ADDR_MODE, {(CSR_DATA_W-2)'($urandom), mode});
   endtask

   // Hold push until the transfer, then leave a random gap
   task automatic push_item(input logic [7:0] b, input logic last);
      int gap;
      req_push    <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(negedge clock);
      while (req_full) @(negedge clock);
      @(posedge clock);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input bit last_at_end);
      for (int i = 0; i < s.len(); i++)
         push_item(s[i], last_at_end && i == s.len() - 1);
   endtask

   // Drop push, wait until all results have come, let the block settle
   task automatic settle_block();
      req_push <= 1'b0;
      @(negedge clock);
      while (expected_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly valid characters in decode modes, any byte otherwise
   function automatic logic [7:0] make_byte(input logic [1:0] mode);
      if (mode == MODE_B64_DEC && $urandom_range(0, 9) != 0)
         return B64_ALPHABET[$urandom_range(0, 63)];
      if (mode == MODE_HEX_DEC && $urandom_range(0, 9) != 0)
         return HEX_DIGITS[$urandom_range(0, 21)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int group_size(input logic [1:0] mode);
      case (mode)
         MODE_B64_ENC: return 3;
         MODE_B64_DEC: return 4;
         MODE_HEX_ENC: return 1;
         default:      return 2;
      endcase
   endfunction

   // One random phase: messages in the given mode, then a dangling fragment
   task automatic run_phase(input logic [1:0] mode);
      int items;
      int len;
      items = 0;
      while (items < PHASE_ITEMS) begin
         if ($urandom_range(0, 99) < 80)
            len = group_size(mode) * $urandom_range(1, 4);
         else
            len = $urandom_range(1, 9);
         for (int i = 0; i < len; i++)
            push_item(make_byte(mode), i == len - 1);
         items += len;
      end
      for (int i = $urandom_range(0, 2); i > 0; i--)
         push_item(make_byte(mode), 1'b0);
   endtask

   initial begin
      logic [1:0] mode;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Base64 encode from reset: extreme bytes, then a short message
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'hEF, 1'b0);
      push_item(8'h7F, 1'b1);
      // Write to an unused index must keep the partial group
      push_item("A", 1'b0);
      settle_block();
      csr_write(ADDR_SPARE, CSR_DATA_W'(MODE_HEX_DEC));
      send_text("BC", 1'b1);
      settle_block();

      // Base64 decode: all character classes, a bad character, a short tail
      write_mode(MODE_B64_DEC);
      send_text("TWFu+/09a!zQ", 1'b1);
      push_item("Z", 1'b1);
      settle_block();

      // Hex encode extremes
      write_mode(MODE_HEX_ENC);
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b1);
      settle_block();

      // Hex decode: both cases, a bad character, a short tail
      write_mode(MODE_HEX_DEC);
      send_text("0fA9Gb", 1'b0);
      push_item("c", 1'b1);
      settle_block();

      // Random phases; each one ends drained before the next mode write
      for (int p = 0; p < 8; p++) begin
         mode = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0)
            csr_write(ADDR_SPARE, CSR_DATA_W'($urandom));
         write_mode(mode);
         sender_steady = (p == 3 || p == 6);
         pop_steady    = (p == 2 || p == 5);
         run_phase(mode);
         settle_block();
      end

      // Drain with the consumer always ready
      pop_steady = 1'b1;
      settle_block();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
